@@ src/ycc_pkg.sv @@
// ----------------------------------------------------------------------------
// ycc_pkg: shared types and constants for the 4:2:0 quad to RGBA converter
// Holds the fixed-point coefficients, the widths of the datapath and the
// record that carries one converted pixel between the lanes and the output.
// ----------------------------------------------------------------------------
package ycc_pkg;

  // Number of pixels in one 2x2 block, and the lane index width
  localparam int unsigned NumLanes = 4;
  localparam int unsigned LaneIdxW = 2;

  // Fixed-point format of the conversion
  localparam int unsigned FracBits = 14;
  localparam int unsigned SampleW  = 8;
  // Accumulator: Y*2^14 plus the largest chroma term stays within 25 bits signed
  localparam int unsigned AccW     = 25;
  // Integer part after the shift by FracBits
  localparam int unsigned IntW     = AccW - FracBits;

  // BT.601 full-range coefficients, 14 fraction bits
  localparam logic signed [AccW-1:0] KRedCr   = AccW'(22970);
  localparam logic signed [AccW-1:0] KGreenCb = AccW'(5638);
  localparam logic signed [AccW-1:0] KGreenCr = AccW'(11700);
  localparam logic signed [AccW-1:0] KBlueCb  = AccW'(29032);

  localparam logic [SampleW-1:0] AlphaOpaque = 8'hFF;
  localparam logic [SampleW-1:0] ChanMax     = 8'hFF;
  localparam logic [SampleW-1:0] ChanMin     = 8'h00;
  localparam logic [LaneIdxW-1:0] LastLane   = 2'd3;

  // Chroma contributions shared by all four pixels of a block
  typedef struct packed {
    logic signed [AccW-1:0] red;
    logic signed [AccW-1:0] green;
    logic signed [AccW-1:0] blue;
  } chroma_terms_t;

  // One converted pixel
  typedef struct packed {
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
  } pixel_t;

  // Luma samples of one block, index 0 top-left through 3 bottom-right
  typedef logic [NumLanes-1:0][SampleW-1:0] luma_quad_t;

  // Shift right by FracBits (floor) and saturate to 0..255
  function automatic logic [SampleW-1:0] scale_clip(input logic signed [AccW-1:0] acc);
    logic [IntW-1:0] whole;
    whole = acc[AccW-1:FracBits];
    if (acc[AccW-1]) begin
      scale_clip = ChanMin;
    end else if (|whole[IntW-1:SampleW]) begin
      scale_clip = ChanMax;
    end else begin
      scale_clip = whole[SampleW-1:0];
    end
  endfunction

endpackage

@@ src/ycbcr420_quad_to_rgba.sv @@
// ----------------------------------------------------------------------------
// ycbcr420_quad_to_rgba: 4:2:0 quad to RGBA pixel converter
// Converts one 2x2 block of full-range BT.601 YCbCr into four RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid_i / stall_o) takes one block per transaction: four
//   luma samples and the shared Cb/Cr pair. Output channel (valid_o /
//   stall_i) returns four pixel transactions per block in the order
//   top-left, top-right, bottom-left, bottom-right; last_o marks the fourth.
//   Alpha is always 255 and each color channel saturates to 0..255.
// A block passes the input register with the chroma multipliers, then four
//   parallel lanes into the pixel buffer, from which its pixels are driven.
//   The single pixel-wide output port draining the four-entry pixel buffer
//   sets the block rate. The next block waits in the input register while
//   the current one drains.
// Reset clears both valid flags; no transaction is in flight afterwards.
// When the receiver stalls, the current pixel holds, the buffer keeps the
//   block and stall_o rises once the input register is also occupied.
// ----------------------------------------------------------------------------
module ycbcr420_quad_to_rgba
  import ycc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [SampleW-1:0]  luma_top_left_i,
  input  logic [SampleW-1:0]  luma_top_right_i,
  input  logic [SampleW-1:0]  luma_bottom_left_i,
  input  logic [SampleW-1:0]  luma_bottom_right_i,
  input  logic [SampleW-1:0]  chroma_blue_i,
  input  logic [SampleW-1:0]  chroma_red_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [LaneIdxW-1:0] quad_position_o,
  output logic [SampleW-1:0]  red_o,
  output logic [SampleW-1:0]  green_o,
  output logic [SampleW-1:0]  blue_o,
  output logic [SampleW-1:0]  alpha_o,
  output logic                last_o
);

  logic                  mid_valid;
  logic                  mid_load;
  luma_quad_t            luma;
  chroma_terms_t         terms;
  pixel_t [NumLanes-1:0] pixels;

  // Input register and shared chroma products
  ycc_chroma u_chroma (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (valid_i),
    .stall_o             (stall_o),
    .luma_top_left_i     (luma_top_left_i),
    .luma_top_right_i    (luma_top_right_i),
    .luma_bottom_left_i  (luma_bottom_left_i),
    .luma_bottom_right_i (luma_bottom_right_i),
    .chroma_blue_i       (chroma_blue_i),
    .chroma_red_i        (chroma_red_i),
    .load_i              (mid_load),
    .valid_o             (mid_valid),
    .luma_o              (luma),
    .terms_o             (terms)
  );

  // One lane per pixel of the block
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    ycc_lane u_lane (
      .luma_i  (luma[l]),
      .terms_i (terms),
      .pixel_o (pixels[l])
    );
  end

  // Collect lane results and serialize
  ycc_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (mid_valid),
    .load_o          (mid_load),
    .pixels_i        (pixels),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .quad_position_o (quad_position_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .last_o          (last_o)
  );

endmodule

@@ src/ycc_chroma.sv @@
// ----------------------------------------------------------------------------
// ycc_chroma: input stage
// Registers the luma samples of a block and the three chroma products that
// the four pixels share.
// ----------------------------------------------------------------------------
module ycc_chroma
  import ycc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [SampleW-1:0]   luma_top_left_i,
  input  logic [SampleW-1:0]   luma_top_right_i,
  input  logic [SampleW-1:0]   luma_bottom_left_i,
  input  logic [SampleW-1:0]   luma_bottom_right_i,
  input  logic [SampleW-1:0]   chroma_blue_i,
  input  logic [SampleW-1:0]   chroma_red_i,
  input  logic                 load_i,
  output logic                 valid_o,
  output luma_quad_t           luma_o,
  output chroma_terms_t        terms_o
);

  logic                       valid_q, valid_d;
  logic                       take;
  luma_quad_t                 luma_q;
  chroma_terms_t              terms_q, terms_d;
  logic signed [SampleW-1:0]  cb_c, cr_c;

  // Hold a transaction until the merge stage loads it
  assign stall_o = valid_q && !load_i;
  assign take    = valid_i && !stall_o;
  assign valid_d = take || (valid_q && !load_i);

  // Remove the offset of 128: flip the top bit to get a signed sample
  assign cb_c = {~chroma_blue_i[SampleW-1], chroma_blue_i[SampleW-2:0]};
  assign cr_c = {~chroma_red_i[SampleW-1], chroma_red_i[SampleW-2:0]};

  // Chroma products
  always_comb begin
    terms_d.red   = KRedCr * AccW'(cr_c);
    terms_d.green = -(KGreenCb * AccW'(cb_c)) - (KGreenCr * AccW'(cr_c));
    terms_d.blue  = KBlueCb * AccW'(cb_c);
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      luma_q  <= {luma_bottom_right_i, luma_bottom_left_i,
                  luma_top_right_i, luma_top_left_i};
      terms_q <= terms_d;
    end
  end

  assign valid_o = valid_q;
  assign luma_o  = luma_q;
  assign terms_o = terms_q;

endmodule

@@ src/ycc_lane.sv @@
// ----------------------------------------------------------------------------
// ycc_lane: one pixel conversion lane
// Adds the scaled luma to the shared chroma terms and saturates each channel.
// ----------------------------------------------------------------------------
module ycc_lane
  import ycc_pkg::*;
(
  input  logic [SampleW-1:0] luma_i,
  input  chroma_terms_t      terms_i,
  output pixel_t             pixel_o
);

  logic signed [AccW-1:0] y_c;
  logic signed [AccW-1:0] acc_r, acc_g, acc_b;

  // Scale luma to 14 fraction bits
  assign y_c = $signed(AccW'({luma_i, FracBits'(0)}));

  // Accumulate per channel
  assign acc_r = y_c + terms_i.red;
  assign acc_g = y_c + terms_i.green;
  assign acc_b = y_c + terms_i.blue;

  // Drop the fraction and clamp
  assign pixel_o.red   = scale_clip(acc_r);
  assign pixel_o.green = scale_clip(acc_g);
  assign pixel_o.blue  = scale_clip(acc_b);

endmodule

@@ src/ycc_merge.sv @@
// ----------------------------------------------------------------------------
// ycc_merge: merge and serialize stage
// Captures the four lane results of a block and sends them one pixel per
// transaction in raster order.
// ----------------------------------------------------------------------------
module ycc_merge
  import ycc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  load_o,
  input  pixel_t [NumLanes-1:0] pixels_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [LaneIdxW-1:0]   quad_position_o,
  output logic [SampleW-1:0]    red_o,
  output logic [SampleW-1:0]    green_o,
  output logic [SampleW-1:0]    blue_o,
  output logic [SampleW-1:0]    alpha_o,
  output logic                  last_o
);

  pixel_t [NumLanes-1:0] buf_q;
  logic                  valid_q, valid_d;
  logic [LaneIdxW-1:0]   idx_q, idx_d;
  logic                  send, done, free;
  pixel_t                cur;

  assign send   = valid_q && !stall_i;
  assign done   = send && (idx_q == LastLane);
  assign free   = !valid_q || done;
  assign load_o = valid_i && free;

  // Advance the pixel index; restart on a new block
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_o) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (done) begin
      valid_d = 1'b0;
      idx_d   = '0;
    end else if (send) begin
      idx_d   = idx_q + LaneIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Hold the block's pixels while they drain
  always_ff @(posedge clk_i) begin
    if (load_o) begin
      buf_q <= pixels_i;
    end
  end

  // Drive the current pixel
  assign cur             = buf_q[idx_q];
  assign valid_o         = valid_q;
  assign quad_position_o = idx_q;
  assign red_o           = cur.red;
  assign green_o         = cur.green;
  assign blue_o          = cur.blue;
  assign alpha_o         = AlphaOpaque;
  assign last_o          = (idx_q == LastLane);

endmodule

@@ bench/ycbcr420_quad_to_rgba_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ycbcr420_quad_to_rgba_tb: self-checking bench for the 4:2:0 quad converter
// Drives 2x2 YCbCr blocks through the input channel, computes the four
// expected RGBA pixels of each accepted block in fixed point, and compares
// every pixel that leaves the output channel in order. Both channels see
// random gaps and stalls, with one stretch of steady flow in between.
// ----------------------------------------------------------------------------
module ycbcr420_quad_to_rgba_tb
  import ycc_pkg::*;
();

  // Conversion constants, 14 fraction bits
  localparam int FixShift    = 14;
  localparam int ChromaBias  = 128;
  localparam int CoefRedCr   = 22970;
  localparam int CoefGreenCb = 5638;
  localparam int CoefGreenCr = 11700;
  localparam int CoefBlueCb  = 29032;
  localparam int BlockPixels = 4;
  localparam logic [SampleW-1:0] OpaqueAlpha = 8'hFF;

  typedef struct {
    logic [LaneIdxW-1:0] position;
    logic [SampleW-1:0]  red;
    logic [SampleW-1:0]  green;
    logic [SampleW-1:0]  blue;
    logic [SampleW-1:0]  alpha;
    logic                last;
  } rgba_pixel_t;

  // Expected pixel store: predicts each block, checks pixels in order
  class pixel_ledger;
    rgba_pixel_t pending_pixels[$];
    int mismatches;
    int blocks_noted;
    int pixels_checked;
    int clipped_channels;

    // Floor shift, then saturate to 0..255
    function logic [SampleW-1:0] clip_channel(int acc);
      int whole;
      whole = acc >>> FixShift;
      if (whole < 0) begin
        clipped_channels++;
        return '0;
      end
      if (whole > 255) begin
        clipped_channels++;
        return 8'hFF;
      end
      return SampleW'(whole);
    endfunction

    function void note_block(luma_quad_t luma, logic [SampleW-1:0] cb, logic [SampleW-1:0] cr);
      int cb_delta;
      int cr_delta;
      int red_term;
      int green_term;
      int blue_term;
      int luma_fix;
      rgba_pixel_t px;
      cb_delta   = int'(cb) - ChromaBias;
      cr_delta   = int'(cr) - ChromaBias;
      red_term   = CoefRedCr * cr_delta;
      green_term = -(CoefGreenCb * cb_delta) - CoefGreenCr * cr_delta;
      blue_term  = CoefBlueCb * cb_delta;
      for (int k = 0; k < BlockPixels; k++) begin
        luma_fix    = int'(luma[k]) << FixShift;
        px.position = LaneIdxW'(k);
        px.red      = clip_channel(luma_fix + red_term);
        px.green    = clip_channel(luma_fix + green_term);
        px.blue     = clip_channel(luma_fix + blue_term);
        px.alpha    = OpaqueAlpha;
        px.last     = (k == BlockPixels - 1);
        pending_pixels.push_back(px);
      end
      blocks_noted++;
    endfunction

    function void compare_field(string field, logic [SampleW-1:0] want, logic [SampleW-1:0] got);
      if (got !== want) begin
        $display("%0d ns: pixel %0d %s mismatch, expected %0d, got %0d",
                 $time, pixels_checked, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(logic [LaneIdxW-1:0] position, logic [SampleW-1:0] red,
                              logic [SampleW-1:0] green, logic [SampleW-1:0] blue,
                              logic [SampleW-1:0] alpha, logic last);
      rgba_pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0d ns: unexpected pixel, expected none, got pos %0d rgb %0d/%0d/%0d",
                 $time, position, red, green, blue);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("quad_position", SampleW'(want.position), SampleW'(position));
      compare_field("red", want.red, red);
      compare_field("green", want.green, green);
      compare_field("blue", want.blue, blue);
      compare_field("alpha", want.alpha, alpha);
      compare_field("last", SampleW'(want.last), SampleW'(last));
      pixels_checked++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                valid_i;
  logic                stall_o;
  logic [SampleW-1:0]  luma_top_left_i;
  logic [SampleW-1:0]  luma_top_right_i;
  logic [SampleW-1:0]  luma_bottom_left_i;
  logic [SampleW-1:0]  luma_bottom_right_i;
  logic [SampleW-1:0]  chroma_blue_i;
  logic [SampleW-1:0]  chroma_red_i;
  logic                valid_o;
  logic                stall_i;
  logic [LaneIdxW-1:0] quad_position_o;
  logic [SampleW-1:0]  red_o;
  logic [SampleW-1:0]  green_o;
  logic [SampleW-1:0]  blue_o;
  logic [SampleW-1:0]  alpha_o;
  logic                last_o;

  pixel_ledger ledger = new();
  bit steady_flow;
  int stall_left;

  ycbcr420_quad_to_rgba u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (valid_i),
    .stall_o             (stall_o),
    .luma_top_left_i     (luma_top_left_i),
    .luma_top_right_i    (luma_top_right_i),
    .luma_bottom_left_i  (luma_bottom_left_i),
    .luma_bottom_right_i (luma_bottom_right_i),
    .chroma_blue_i       (chroma_blue_i),
    .chroma_red_i        (chroma_red_i),
    .valid_o             (valid_o),
    .stall_i             (stall_i),
    .quad_position_o     (quad_position_o),
    .red_o               (red_o),
    .green_o             (green_o),
    .blue_o              (blue_o),
    .alpha_o             (alpha_o),
    .last_o              (last_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on run length
  initial begin
    #5_000_000;
    $display("%0d ns: timeout, pixels still awaited: %0d", $time, ledger.pending_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle length: mostly short, now and then long
  function automatic int idle_cycles();
    if ($urandom_range(0, 4) != 0) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 25);
  endfunction

  // Receiver stalls: random bursts, none during steady flow
  always @(posedge clk_i) begin
    if (!rst_ni || steady_flow) begin
      stall_left = 0;
      stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = idle_cycles() - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  // Sample outputs mid-cycle; the transaction completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      ledger.check_pixel(quad_position_o, red_o, green_o, blue_o, alpha_o, last_o);
    end
  end

  // Offer one block, hold it until accepted, then record its expected pixels
  task automatic send_quad(input logic [SampleW-1:0] tl, input logic [SampleW-1:0] tr,
                           input logic [SampleW-1:0] bl, input logic [SampleW-1:0] br,
                           input logic [SampleW-1:0] cb, input logic [SampleW-1:0] cr);
    int gap;
    luma_quad_t luma;
    gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_cycles();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i             <= 1'b1;
    luma_top_left_i     <= tl;
    luma_top_right_i    <= tr;
    luma_bottom_left_i  <= bl;
    luma_bottom_right_i <= br;
    chroma_blue_i       <= cb;
    chroma_red_i        <= cr;
    do @(negedge clk_i); while (stall_o);
    @(posedge clk_i);
    luma = {br, bl, tr, tl};
    ledger.note_block(luma, cb, cr);
  endtask

  // Random block: mostly free values, some near-neutral chroma, some luma at the rails
  task automatic send_random_quad();
    int kind;
    logic [SampleW-1:0] luma_pick[BlockPixels];
    logic [SampleW-1:0] cb;
    logic [SampleW-1:0] cr;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < BlockPixels; k++) begin
      if (kind == 9) begin
        luma_pick[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        luma_pick[k] = SampleW'($urandom_range(0, 255));
      end
    end
    if (kind >= 6 && kind <= 8) begin
      cb = SampleW'($urandom_range(ChromaBias - 8, ChromaBias + 8));
      cr = SampleW'($urandom_range(ChromaBias - 8, ChromaBias + 8));
    end else begin
      cb = SampleW'($urandom_range(0, 255));
      cr = SampleW'($urandom_range(0, 255));
    end
    send_quad(luma_pick[0], luma_pick[1], luma_pick[2], luma_pick[3], cb, cr);
  endtask

  initial begin
    rst_ni              <= 1'b0;
    valid_i             <= 1'b0;
    stall_i             <= 1'b0;
    luma_top_left_i     <= '0;
    luma_top_right_i    <= '0;
    luma_bottom_left_i  <= '0;
    luma_bottom_right_i <= '0;
    chroma_blue_i       <= '0;
    chroma_red_i        <= '0;
    steady_flow          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rails, neutral chroma, each channel clipping both ways, floor near zero
    send_quad(8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128);
    send_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128);
    send_quad(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_quad(8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255);
    send_quad(8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0);
    send_quad(8'd16,  8'd235, 8'd128, 8'd64,  8'd128, 8'd128);
    send_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd128);
    send_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd128);
    send_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd0);
    send_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd255);
    send_quad(8'd1,   8'd2,   8'd0,   8'd3,   8'd127, 8'd127);
    send_quad(8'd254, 8'd255, 8'd253, 8'd252, 8'd129, 8'd129);
    send_quad(8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA);
    send_quad(8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55);
    send_quad(8'd0,   8'd1,   8'd2,   8'd3,   8'd129, 8'd127);
    send_quad(8'd200, 8'd100, 8'd50,  8'd25,  8'd64,  8'd192);

    // Random: six phases, the third with no idling on either side
    for (int phase = 0; phase < 6; phase++) begin
      steady_flow = (phase == 2);
      repeat (30) send_random_quad();
    end
    steady_flow = 1'b0;
    valid_i <= 1'b0;

    // Drain, then wait for any stray pixel
    while (ledger.pending_pixels.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d blocks and %0d pixels; %0d channel values saturated.",
             ledger.blocks_noted, ledger.pixels_checked, ledger.clipped_channels);
    $display("Mismatches found: %0d", ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ycc_pkg.sv
src/ycc_chroma.sv
src/ycc_lane.sv
src/ycc_merge.sv
src/ycbcr420_quad_to_rgba.sv
bench/ycbcr420_quad_to_rgba_tb.sv
